FILE: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // event codes carried in the action field
   typedef enum logic [2:0] {
      ACT_CREATE = 3'd0,
      ACT_YIELD  = 3'd1,
      ACT_EXIT   = 3'd2,
      ACT_TICK   = 3'd3,
      ACT_WAKE   = 3'd4,
      ACT_SLEEP  = 3'd5,
      ACT_BLOCK  = 3'd6,
      ACT_RSVD   = 3'd7
   } action_type;

   // per-slot task status
   typedef enum logic [2:0] {
      TS_FREE     = 3'd0,
      TS_READY    = 3'd1,
      TS_RUNNING  = 3'd2,
      TS_SLEEPING = 3'd3,
      TS_BLOCKED  = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_FREE_SCAN,
      SQ_PRED_WALK,
      SQ_SWEEP,
      SQ_SEARCH,
      SQ_DONE
   } seq_state_type;

   // what a ring search does with its hit
   typedef enum logic [1:0] {
      SM_YIELD,
      SM_HAND,
      SM_RESEL
   } mode_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sleep_count;
   } req_type;

   typedef struct packed {
      logic [3:0]  current_slot;
      logic        switched;
      logic        idle;
      logic [3:0]  new_slot;
      logic [31:0] new_id;
      logic        create_failed;
      logic        freed_valid;
      logic [3:0]  freed_slot;
   } rsp_type;

endpackage

FILE: rtl/core/rrts_core.sv
// ----------------------------------------------------------------------------
// rrts_core
// Task table and sequencer; one slot is visited per cycle by the shared
// step unit for free scans, ring walks and tick/wake sweeps.
// ----------------------------------------------------------------------------
module rrts_core
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    ready,
   output logic    done,
   output rsp_type result
);

   localparam int SW = $clog2(MAX_TASKS);
   localparam logic [SW-1:0] LAST = SW'(MAX_TASKS - 1);

   // task table
   status_type    status_ff [MAX_TASKS];
   logic          in_use_ff [MAX_TASKS];
   logic [SW-1:0] link_ff   [MAX_TASKS];
   logic [31:0]   sleep_ff  [MAX_TASKS];

   // scheduler state
   logic [SW-1:0] run_ff, head_ff;
   logic          empty_ff, idle_ff;
   logic [31:0]   ident_ff;

   // sequencer
   seq_state_type state_ff, state_in;
   mode_type      mode_ff;
   logic [2:0]    act_ff;
   logic [SW-1:0] ptr_ff, cnt_ff, origin_ff;

   // result capture
   logic [SW-1:0] before_slot_ff, new_slot_ff, freed_slot_ff;
   logic          before_idle_ff, fail_ff, freed_v_ff;
   logic [31:0]   new_id_ff;

   logic          hit, at_end, free_hit, pred_hit, resel_go, exit_go;
   logic [SW-1:0] cur, pred_sel, start_ptr;
   logic [SW+3:0] run_ext, new_ext, freed_ext;

   // step unit compares
   assign cur      = run_ff;
   assign hit      = in_use_ff[ptr_ff] &&
                     (status_ff[ptr_ff] == TS_READY || status_ff[ptr_ff] == TS_RUNNING);
   assign at_end   = (cnt_ff == LAST);
   assign free_hit = !in_use_ff[ptr_ff];
   assign pred_hit = (link_ff[ptr_ff] == cur);
   assign pred_sel = pred_hit ? ptr_ff : link_ff[ptr_ff];
   assign resel_go = idle_ff && !empty_ff;
   assign exit_go  = (req.action == ACT_EXIT) && !idle_ff;

   // first slot visited by the event
   always_comb begin
      case (req.action)
         ACT_CREATE, ACT_TICK, ACT_WAKE: start_ptr = '0;
         ACT_EXIT: start_ptr = head_ff;
         default:  start_ptr = link_ff[cur];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               case (req.action)
                  ACT_CREATE: state_in = SQ_FREE_SCAN;
                  ACT_YIELD:  state_in = (!idle_ff || resel_go) ? SQ_SEARCH : SQ_DONE;
                  ACT_EXIT: begin
                     if (idle_ff || link_ff[cur] == cur) state_in = SQ_DONE;
                     else state_in = SQ_PRED_WALK;
                  end
                  ACT_TICK, ACT_WAKE: state_in = SQ_SWEEP;
                  ACT_SLEEP, ACT_BLOCK: state_in = idle_ff ? SQ_DONE : SQ_SEARCH;
                  default: state_in = SQ_DONE;
               endcase
            end
         end
         SQ_FREE_SCAN: if (free_hit || at_end) state_in = SQ_DONE;
         SQ_PRED_WALK: if (pred_hit || at_end) state_in = SQ_SEARCH;
         SQ_SWEEP:     if (at_end) state_in = resel_go ? SQ_SEARCH : SQ_DONE;
         SQ_SEARCH:    if (hit || at_end) state_in = SQ_DONE;
         SQ_DONE:      state_in = SQ_IDLE;
         default:      state_in = SQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ready = 1'b0;
      done  = 1'b0;
      case (state_ff)
         SQ_IDLE: ready = 1'b1;
         SQ_DONE: done  = 1'b1;
         default: ;
      endcase
   end

   // result fields
   assign run_ext   = {4'b0, run_ff};
   assign new_ext   = {4'b0, new_slot_ff};
   assign freed_ext = {4'b0, freed_slot_ff};
   always_comb begin
      result.current_slot  = run_ext[3:0];
      result.switched      = (before_idle_ff != idle_ff) ||
                             (!idle_ff && before_slot_ff != run_ff);
      result.idle          = idle_ff;
      result.new_slot      = new_ext[3:0];
      result.new_id        = new_id_ff;
      result.create_failed = fail_ff;
      result.freed_valid   = freed_v_ff;
      result.freed_slot    = freed_ext[3:0];
   end

   // table and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            status_ff[i] <= (i == 0) ? TS_RUNNING : TS_FREE;
            in_use_ff[i] <= (i == 0);
            link_ff[i]   <= SW'(i);
            sleep_ff[i]  <= '0;
         end
         run_ff   <= '0;
         head_ff  <= '0;
         empty_ff <= 1'b0;
         idle_ff  <= 1'b0;
         ident_ff <= 32'd1;
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            SQ_IDLE: begin
               if (start) begin
                  act_ff         <= req.action;
                  before_slot_ff <= run_ff;
                  before_idle_ff <= idle_ff;
                  new_slot_ff    <= '0;
                  new_id_ff      <= '0;
                  fail_ff        <= 1'b0;
                  freed_v_ff     <= exit_go;
                  freed_slot_ff  <= exit_go ? cur : '0;
                  cnt_ff         <= '0;
                  origin_ff      <= cur;
                  ptr_ff         <= start_ptr;
                  case (req.action)
                     ACT_YIELD: mode_ff <= idle_ff ? SM_RESEL : SM_YIELD;
                     ACT_EXIT: begin
                        if (!idle_ff) begin
                           in_use_ff[cur] <= 1'b0;
                           status_ff[cur] <= TS_FREE;
                           if (link_ff[cur] == cur) begin
                              empty_ff <= 1'b1;
                              idle_ff  <= 1'b1;
                           end
                        end
                     end
                     ACT_SLEEP: begin
                        mode_ff <= SM_HAND;
                        if (!idle_ff) begin
                           status_ff[cur] <= TS_SLEEPING;
                           sleep_ff[cur]  <= req.sleep_count;
                        end
                     end
                     ACT_BLOCK: begin
                        mode_ff <= SM_HAND;
                        if (!idle_ff) status_ff[cur] <= TS_BLOCKED;
                     end
                     default: ;
                  endcase
               end
            end
            // lowest free slot, one per cycle
            SQ_FREE_SCAN: begin
               if (free_hit) begin
                  in_use_ff[ptr_ff] <= 1'b1;
                  status_ff[ptr_ff] <= TS_READY;
                  sleep_ff[ptr_ff]  <= '0;
                  new_id_ff         <= ident_ff;
                  new_slot_ff       <= ptr_ff;
                  ident_ff          <= ident_ff + 32'd1;
                  if (empty_ff) begin
                     link_ff[ptr_ff] <= ptr_ff;
                     head_ff         <= ptr_ff;
                     empty_ff        <= 1'b0;
                     run_ff          <= ptr_ff;
                  end else begin
                     link_ff[ptr_ff] <= link_ff[cur];
                     link_ff[cur]    <= ptr_ff;
                  end
               end else if (at_end) begin
                  fail_ff <= 1'b1;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            // find the predecessor of the exiting slot, then unlink it
            SQ_PRED_WALK: begin
               if (pred_hit || at_end) begin
                  link_ff[pred_sel] <= link_ff[cur];
                  link_ff[cur]      <= cur;
                  if (head_ff == cur) head_ff <= link_ff[cur];
                  mode_ff   <= SM_HAND;
                  origin_ff <= pred_sel;
                  ptr_ff    <= link_ff[cur];
                  cnt_ff    <= '0;
               end else begin
                  ptr_ff <= link_ff[ptr_ff];
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            // tick or wake over every slot
            SQ_SWEEP: begin
               if (in_use_ff[ptr_ff]) begin
                  if (act_ff == ACT_TICK && status_ff[ptr_ff] == TS_SLEEPING) begin
                     if (sleep_ff[ptr_ff] <= 32'd1) status_ff[ptr_ff] <= TS_READY;
                     if (sleep_ff[ptr_ff] != 32'd0) sleep_ff[ptr_ff] <= sleep_ff[ptr_ff] - 32'd1;
                  end
                  if (act_ff == ACT_WAKE && status_ff[ptr_ff] == TS_BLOCKED)
                     status_ff[ptr_ff] <= TS_READY;
               end
               if (at_end) begin
                  mode_ff   <= SM_RESEL;
                  origin_ff <= run_ff;
                  ptr_ff    <= link_ff[run_ff];
                  cnt_ff    <= '0;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            // ring search for the next ready or running slot
            SQ_SEARCH: begin
               if (hit) begin
                  if (mode_ff == SM_YIELD) begin
                     if (ptr_ff != origin_ff) begin
                        status_ff[origin_ff] <= TS_READY;
                        status_ff[ptr_ff]    <= TS_RUNNING;
                        run_ff               <= ptr_ff;
                     end
                  end else begin
                     status_ff[ptr_ff] <= TS_RUNNING;
                     run_ff            <= ptr_ff;
                     idle_ff           <= 1'b0;
                  end
               end else if (at_end) begin
                  if (mode_ff == SM_HAND) begin
                     run_ff  <= origin_ff;
                     idle_ff <= 1'b1;
                  end
               end else begin
                  ptr_ff <= link_ff[ptr_ff];
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

FILE: rtl/core/rrts_out_reg.sv
// ----------------------------------------------------------------------------
// rrts_out_reg
// Result register holding one finished result until its transfer.
// ----------------------------------------------------------------------------
module rrts_out_reg
   import rrts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // hold until transfer, load when a result completes
   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/core/round_robin_task_scheduler.sv
// exit walks the ring for the predecessor and then searches; tick and wake
// sweep all MAX_TASKS slots, then may search the ring; one slot per cycle
// one event at a time: next transfer in after the result transfers out
// synchronous active-high reset: slot 0 running, sole ring member, id counter 1
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin task scheduler over a ring of task slots.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    core_ready, core_done, start;
   rsp_type core_result;

   // accept only with the core free and no result pending
   assign req_stall = !(core_ready && !rsp_valid);
   assign start     = req_valid && !req_stall;

   rrts_core #(
      .MAX_TASKS(MAX_TASKS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_data),
      .ready (core_ready),
      .done  (core_done),
      .result(core_result)
   );

   rrts_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (core_done),
      .load_data(core_result),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/core/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrts_checker
   import rrts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no new event while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("event accepted with result pending");

   // failed create reports no slot and no id
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.create_failed |->
         rsp_data.new_id == 32'd0 && rsp_data.new_slot == 4'd0)
      else $error("failed create reported a task");

   // create and exit never in the same result
   a_fail_vs_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.freed_valid |-> !rsp_data.create_failed && rsp_data.new_id == 32'd0)
      else $error("exit result carries create fields");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

FILE: dv/round_robin_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_tb
// Self-checking bench: a cycle-free predictor of the task ring tracks every
// event transfer, and each result transfer is compared field by field with
// the oldest prediction. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_tb;
   import rrts_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // predictor state
   status_type sched_status [NSLOT];
   logic [31:0] sched_sleep [NSLOT];
   logic [3:0]  sched_link [NSLOT];
   logic        sched_used [NSLOT];
   logic [3:0]  sched_run;
   logic [3:0]  sched_head;
   logic        sched_empty;
   logic [31:0] sched_ident;
   logic        sched_idle;

   rsp_type sched_expected [$];
   int      error_count;
   int      idle_cycles;
   int      sent_count;
   int      rsp_count;
   int      switch_count;
   int      fail_count;
   int      stall_mode;

   round_robin_task_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void sched_reset();
      for (int i = 0; i < NSLOT; i++) begin
         sched_status[i] = TS_FREE;
         sched_sleep[i] = '0;
         sched_link[i] = 4'(i);
         sched_used[i] = 1'b0;
      end
      sched_status[0] = TS_RUNNING;
      sched_used[0] = 1'b1;
      sched_run = '0;
      sched_head = '0;
      sched_empty = 1'b0;
      sched_ident = 32'd1;
      sched_idle = 1'b0;
   endfunction

   // first ready or running slot after origin, origin last; -1 if none
   function automatic int ring_search(logic [3:0] origin);
      logic [3:0] s;
      s = sched_link[origin];
      for (int i = 0; i < NSLOT; i++) begin
         if (sched_used[s] && (sched_status[s] == TS_READY || sched_status[s] == TS_RUNNING))
            return int'(s);
         s = sched_link[s];
      end
      return -1;
   endfunction

   function automatic void hand_over(logic [3:0] origin);
      int n;
      n = ring_search(origin);
      if (n >= 0) begin
         sched_status[n] = TS_RUNNING;
         sched_run = 4'(n);
         sched_idle = 1'b0;
      end else begin
         sched_run = origin;
         sched_idle = 1'b1;
      end
   endfunction

   function automatic void reselect();
      int n;
      if (sched_idle && !sched_empty) begin
         n = ring_search(sched_run);
         if (n >= 0) begin
            sched_status[n] = TS_RUNNING;
            sched_run = 4'(n);
            sched_idle = 1'b0;
         end
      end
   endfunction

   // apply one event to the predictor and return the expected result
   function automatic rsp_type sched_predict(req_type rq);
      rsp_type r;
      logic [3:0] prev_run, cur, nx, p;
      logic prev_idle;
      int f, n;
      r = '0;
      prev_run = sched_run;
      prev_idle = sched_idle;
      cur = sched_run;
      case (rq.action)
         ACT_CREATE: begin
            f = -1;
            for (int i = NSLOT - 1; i >= 0; i--)
               if (!sched_used[i]) f = i;
            if (f < 0) begin
               r.create_failed = 1'b1;
            end else begin
               sched_used[f] = 1'b1;
               sched_status[f] = TS_READY;
               sched_sleep[f] = '0;
               r.new_id = sched_ident;
               r.new_slot = 4'(f);
               sched_ident = sched_ident + 32'd1;
               if (sched_empty) begin
                  sched_link[f] = 4'(f);
                  sched_head = 4'(f);
                  sched_empty = 1'b0;
                  sched_run = 4'(f);
               end else begin
                  sched_link[f] = sched_link[cur];
                  sched_link[cur] = 4'(f);
               end
            end
         end
         ACT_YIELD: begin
            if (sched_idle) begin
               reselect();
            end else begin
               n = ring_search(cur);
               if (n >= 0 && n != int'(cur)) begin
                  sched_status[cur] = TS_READY;
                  sched_status[n] = TS_RUNNING;
                  sched_run = 4'(n);
               end
            end
         end
         ACT_EXIT: begin
            if (!sched_idle) begin
               nx = sched_link[cur];
               p = sched_head;
               for (int i = 0; i < NSLOT; i++) begin
                  if (sched_link[p] == cur) break;
                  p = sched_link[p];
               end
               sched_used[cur] = 1'b0;
               sched_status[cur] = TS_FREE;
               sched_sleep[cur] = '0;
               r.freed_valid = 1'b1;
               r.freed_slot = cur;
               if (nx == cur) begin
                  sched_empty = 1'b1;
                  sched_idle = 1'b1;
               end else begin
                  sched_link[p] = nx;
                  sched_link[cur] = cur;
                  if (sched_head == cur) sched_head = nx;
                  hand_over(p);
               end
            end
         end
         ACT_TICK: begin
            for (int i = 0; i < NSLOT; i++)
               if (sched_used[i] && sched_status[i] == TS_SLEEPING) begin
                  if (sched_sleep[i] != 0) sched_sleep[i] = sched_sleep[i] - 1;
                  if (sched_sleep[i] == 0) sched_status[i] = TS_READY;
               end
            reselect();
         end
         ACT_WAKE: begin
            for (int i = 0; i < NSLOT; i++)
               if (sched_used[i] && sched_status[i] == TS_BLOCKED)
                  sched_status[i] = TS_READY;
            reselect();
         end
         ACT_SLEEP, ACT_BLOCK: begin
            if (!sched_idle) begin
               if (rq.action == ACT_SLEEP) begin
                  sched_status[cur] = TS_SLEEPING;
                  sched_sleep[cur] = rq.sleep_count;
               end else begin
                  sched_status[cur] = TS_BLOCKED;
               end
               hand_over(cur);
            end
         end
         default: begin
         end
      endcase
      r.switched = (prev_idle != sched_idle) || (!sched_idle && prev_run != sched_run);
      r.idle = sched_idle;
      r.current_slot = sched_run;
      return r;
   endfunction

   // send one event and wait for its transfer
   task automatic send_event(logic [2:0] act, logic [31:0] cnt);
      req_type rq;
      rq.action = act;
      rq.sleep_count = cnt;
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sched_expected.push_back(sched_predict(rq));
      sent_count++;
      req_valid <= 1'b0;
      // the block stalls while it works, so this costs no throughput
      @(posedge clock);
   endtask

   // random gaps between bursts
   task automatic send_burst_event(logic [2:0] act, logic [31:0] cnt);
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 12)) @(posedge clock);
      send_event(act, cnt);
   endtask

   task automatic wait_drained();
      while (sched_expected.size() != 0) @(posedge clock);
      repeat (2 * NSLOT + 4) @(posedge clock);
   endtask

   // directed: every action, extremes of sleep count, full table
   task automatic test_directed();
      send_event(ACT_YIELD, '0);
      send_event(ACT_TICK, '0);
      send_event(ACT_WAKE, '0);
      for (int i = 0; i < NSLOT; i++) send_event(ACT_CREATE, 32'hFFFF_FFFF);
      send_event(ACT_YIELD, '0);
      send_event(ACT_SLEEP, '0);
      send_event(ACT_BLOCK, '0);
      send_event(ACT_SLEEP, 32'hFFFF_FFFF);
      send_event(ACT_TICK, '0);
      send_event(ACT_WAKE, '0);
      send_event(ACT_EXIT, '0);
      send_event(ACT_RSVD, 32'h5555_AAAA);
      wait_drained();
   endtask

   // exit tasks until the scheduler is idle, then act on an idle scheduler
   task automatic test_empty_ring();
      for (int i = 0; i < NSLOT + 2; i++) send_event(ACT_EXIT, '0);
      send_event(ACT_SLEEP, 32'd3);
      send_event(ACT_BLOCK, '0);
      send_event(ACT_YIELD, '0);
      send_event(ACT_CREATE, '0);
      send_event(ACT_CREATE, '0);
      send_event(ACT_TICK, '0);
      wait_drained();
   endtask

   // random events weighted toward short sleeps and a populated ring
   task automatic test_random(int n);
      logic [2:0]  act;
      logic [31:0] cnt;
      for (int i = 0; i < n; i++) begin
         act = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0) act = ACT_CREATE;
         if ($urandom_range(0, 5) == 0) act = ACT_TICK;
         case ($urandom_range(0, 9))
            0: cnt = $urandom();
            1: cnt = 32'hFFFF_FFFF;
            default: cnt = 32'($urandom_range(0, 4));
         endcase
         send_burst_event(act, cnt);
         if (i == n / 2) wait_drained();
      end
      wait_drained();
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type ex;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (sched_expected.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            ex = sched_expected.pop_front();
            if (rsp_data.switched) switch_count++;
            if (rsp_data.create_failed) fail_count++;
            if (rsp_data.current_slot !== ex.current_slot) begin
               $error("current_slot exp %0d got %0d", ex.current_slot, rsp_data.current_slot);
               error_count++;
            end
            if (rsp_data.switched !== ex.switched) begin
               $error("switched exp %0d got %0d", ex.switched, rsp_data.switched);
               error_count++;
            end
            if (rsp_data.idle !== ex.idle) begin
               $error("idle exp %0d got %0d", ex.idle, rsp_data.idle);
               error_count++;
            end
            if (rsp_data.new_slot !== ex.new_slot) begin
               $error("new_slot exp %0d got %0d", ex.new_slot, rsp_data.new_slot);
               error_count++;
            end
            if (rsp_data.new_id !== ex.new_id) begin
               $error("new_id exp %0h got %0h", ex.new_id, rsp_data.new_id);
               error_count++;
            end
            if (rsp_data.create_failed !== ex.create_failed) begin
               $error("create_failed exp %0d got %0d", ex.create_failed,
                      rsp_data.create_failed);
               error_count++;
            end
            if (rsp_data.freed_valid !== ex.freed_valid) begin
               $error("freed_valid exp %0d got %0d", ex.freed_valid, rsp_data.freed_valid);
               error_count++;
            end
            if (rsp_data.freed_slot !== ex.freed_slot) begin
               $error("freed_slot exp %0d got %0d", ex.freed_slot, rsp_data.freed_slot);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern, changing its mood now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      error_count = 0;
      sent_count = 0;
      rsp_count = 0;
      switch_count = 0;
      fail_count = 0;
      sched_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_empty_ring();
      test_random(1800);
      $display("covered %0d events, %0d results, %0d task switches, %0d failed creates",
               sent_count, rsp_count, switch_count, fail_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/rrts_pkg.sv
rtl/core/rrts_core.sv
rtl/core/rrts_out_reg.sv
rtl/core/round_robin_task_scheduler.sv
rtl/core/rrts_checker.sv
dv/round_robin_task_scheduler_tb.sv
